/* rtl/sha512_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-512 shared definitions
// Round constants, initial hash values, state encodings and the queue entry.
// ----------------------------------------------------------------------------
package sha512_pkg;

  localparam int WordW = 64;

  typedef logic [WordW-1:0] word_t;

  // Queue entry handed from front to back: one padded block word.
  typedef struct packed {
    word_t word;
    logic  blk_end;   // word completes a 16-word block
    logic  msg_end;   // block is the last of the message
  } qent_t;

  typedef enum logic [1:0] {
    BK_LOAD  = 2'd0,
    BK_ROUND = 2'd1,
    BK_FOLD  = 2'd2,
    BK_EMIT  = 2'd3
  } bk_state_t;

  typedef enum logic [1:0] {
    FR_IDLE = 2'd0,
    FR_PAD  = 2'd1
  } fr_state_t;

  localparam word_t IV [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam word_t RK [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

endpackage

/* rtl/sha512_front.sv */
// ----------------------------------------------------------------------------
// SHA-512 front end
// Accepts message words, counts bytes and produces padded block words.
// ----------------------------------------------------------------------------
module sha512_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [63:0]        in_msg_word,
  input  logic [3:0]         in_valid_bytes,
  input  logic               in_end_of_message,
  output logic               q_valid,
  input  logic               q_full,
  output sha512_pkg::qent_t  q_data
);
  import sha512_pkg::*;

  fr_state_t   st_r, st_nxt;
  logic [63:0] bytes_r, bytes_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic        extra_r, extra_nxt;   // full end word: 0x80 word still due
  logic        wrap_r, wrap_nxt;     // 0x80 word took slot 14: length goes in next block
  word_t       wd;
  logic        push;
  logic [3:0]  vb;
  logic [63:0] keep;
  logic [63:0] tot;

  always_comb begin
    vb   = (in_valid_bytes > 4'd8) ? 4'd8 : in_valid_bytes;
    keep = (vb == 4'd0) ? 64'd0 : ~(64'hffff_ffff_ffff_ffff >> {vb, 3'b000});
    tot  = bytes_r + {60'd0, vb};
  end

  always_comb begin
    st_nxt    = st_r;
    bytes_nxt = bytes_r;
    pos_nxt   = pos_r;
    extra_nxt = extra_r;
    wrap_nxt  = wrap_r;
    push      = 1'b0;
    wd        = '0;
    in_stall  = 1'b1;
    unique case (st_r)
      FR_IDLE: begin
        in_stall = q_full;
        if (in_valid && !q_full) begin
          push = 1'b1;
          if (!in_end_of_message) begin
            wd        = in_msg_word;
            bytes_nxt = bytes_r + 64'd8;
          end else begin
            bytes_nxt = tot;
            st_nxt    = FR_PAD;
            if (vb == 4'd8) begin
              wd        = in_msg_word;
              extra_nxt = 1'b1;
            end else begin
              wd = (in_msg_word & keep) | (64'h8000_0000_0000_0000 >> {vb, 3'b000});
              wrap_nxt = (pos_r == 4'd14);
            end
          end
          pos_nxt = pos_r + 4'd1;
        end
      end
      FR_PAD: begin
        if (!q_full) begin
          push    = 1'b1;
          pos_nxt = pos_r + 4'd1;
          if (extra_r) begin
            wd        = 64'h8000_0000_0000_0000;
            extra_nxt = 1'b0;
            wrap_nxt  = (pos_r == 4'd14);
          end else if (pos_r == 4'd15 && !wrap_r) begin
            wd      = {bytes_r[60:0], 3'b000};
            st_nxt  = FR_IDLE;
            bytes_nxt = '0;
          end else begin
            wd = '0;
            if (pos_r == 4'd15) wrap_nxt = 1'b0;
          end
        end
      end
      default: st_nxt = FR_IDLE;
    endcase
  end

  assign q_valid        = push;
  assign q_data.word    = wd;
  assign q_data.blk_end = (pos_r == 4'd15);
  assign q_data.msg_end = (st_r == FR_PAD) && !extra_r && !wrap_r && (pos_r == 4'd15);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= FR_IDLE;
      bytes_r <= '0;
      pos_r   <= '0;
      extra_r <= 1'b0;
      wrap_r  <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      bytes_r <= bytes_nxt;
      pos_r   <= pos_nxt;
      extra_r <= extra_nxt;
      wrap_r  <= wrap_nxt;
    end
  end

endmodule

/* rtl/sha512_queue.sv */
// ----------------------------------------------------------------------------
// SHA-512 word queue
// Small FIFO of padded block words between front and back end.
// ----------------------------------------------------------------------------
module sha512_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  sha512_pkg::qent_t  wr_data,
  output logic               full,
  input  logic               rd_en,
  output logic               empty,
  output sha512_pkg::qent_t  rd_data
);
  import sha512_pkg::*;

  qent_t       mem_r [4];
  logic [1:0]  wp_r, rp_r;
  logic [2:0]  cnt_r;

  assign full    = (cnt_r == 3'd4);
  assign empty   = (cnt_r == 3'd0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 2'd1;
      if (rd_en) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, wr_en} - {2'd0, rd_en};
    end
  end

endmodule

/* rtl/sha512_back.sv */
// ----------------------------------------------------------------------------
// SHA-512 back end
// Loads block words, runs 80 rounds, folds the chain and emits the digest.
// ----------------------------------------------------------------------------
module sha512_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  output logic               q_pop,
  input  sha512_pkg::qent_t  q_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        out_digest_word,
  output logic [2:0]         out_word_index,
  output logic               out_last_word
);
  import sha512_pkg::*;

  bk_state_t  st_r, st_nxt;
  word_t      w_r [16];
  word_t      h_r [8];
  word_t      v_r [8];
  logic [6:0] rnd_r;
  logic       fin_r;
  logic [2:0] oi_r;

  word_t x15, x2, g0, g1, wt, big0, big1, ch, maj, t1, t2;

  always_comb begin
    x15  = w_r[1];
    x2   = w_r[14];
    g0   = rotr(x15, 1) ^ rotr(x15, 8) ^ (x15 >> 7);
    g1   = rotr(x2, 19) ^ rotr(x2, 61) ^ (x2 >> 6);
    wt   = (rnd_r < 7'd16) ? w_r[0] : (w_r[0] + g0 + w_r[9] + g1);
    big1 = rotr(v_r[4], 14) ^ rotr(v_r[4], 18) ^ rotr(v_r[4], 41);
    ch   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1   = v_r[7] + big1 + ch + RK[rnd_r] + wt;
    big0 = rotr(v_r[0], 28) ^ rotr(v_r[0], 34) ^ rotr(v_r[0], 39);
    maj  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2   = big0 + maj;
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_LOAD:  if (!q_empty && q_data.blk_end) st_nxt = BK_ROUND;
      BK_ROUND: if (rnd_r == 7'd79) st_nxt = BK_FOLD;
      BK_FOLD:  st_nxt = fin_r ? BK_EMIT : BK_LOAD;
      BK_EMIT:  if (!out_stall && oi_r == 3'd7) st_nxt = BK_LOAD;
      default:  st_nxt = BK_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    q_pop     = (st_r == BK_LOAD) && !q_empty;
    out_valid = (st_r == BK_EMIT);
  end

  assign out_digest_word = h_r[oi_r];
  assign out_word_index  = oi_r;
  assign out_last_word   = (oi_r == 3'd7);

  // schedule window: shift in new words while loading, rotate during rounds
  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= q_data.word;
    end else if (st_r == BK_ROUND) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wt;
    end
    if (st_r == BK_LOAD && q_pop && q_data.blk_end) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (st_r == BK_ROUND) begin
      for (int i = 1; i < 8; i++) v_r[i] <= v_r[i-1];
      v_r[4] <= v_r[3] + t1;
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= BK_LOAD;
      rnd_r <= '0;
      fin_r <= 1'b0;
      oi_r  <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= IV[i];
    end else begin
      st_r <= st_nxt;
      if (q_pop && q_data.blk_end) fin_r <= q_data.msg_end;
      if (st_r == BK_ROUND) rnd_r <= (rnd_r == 7'd79) ? 7'd0 : rnd_r + 7'd1;
      if (st_r == BK_FOLD) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end
      if (st_r == BK_EMIT && !out_stall) begin
        oi_r <= oi_r + 3'd1;
        if (oi_r == 3'd7) begin
          for (int i = 0; i < 8; i++) h_r[i] <= IV[i];
          fin_r <= 1'b0;
        end
      end
    end
  end

endmodule

/* rtl/sha512_hash_engine_unit.sv */
// SHA-512 engine: every 16 padded words are loaded, then run through 80 rounds
// and folded into the chain; the back end pops no words while rounds run.
// An end word adds 2 to 18 padding words, so the last block may be an extra
// one, then eight digest words, one per cycle while out_stall is low.
// Synchronous reset loads the initial hash values and empties the queue.
// ----------------------------------------------------------------------------
// SHA-512 hash engine top level
// Front end padding, word queue and compression back end.
// ----------------------------------------------------------------------------
module sha512_hash_engine_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_msg_word,
  input  logic [3:0]  in_valid_bytes,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha512_pkg::*;

  qent_t wr_d, rd_d;
  logic  wr_en, full, rd_en, empty;

  sha512_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_msg_word, .in_valid_bytes,
    .in_end_of_message, .q_valid(wr_en), .q_full(full), .q_data(wr_d)
  );

  sha512_queue u_queue (
    .clk, .rst_n, .wr_en, .wr_data(wr_d), .full, .rd_en, .empty, .rd_data(rd_d)
  );

  sha512_back u_back (
    .clk, .rst_n, .q_empty(empty), .q_pop(rd_en), .q_data(rd_d), .out_valid,
    .out_stall, .out_digest_word, .out_word_index, .out_last_word
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && full)) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && empty)) else $error("pop from empty queue");
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd7)))
    else $error("last word flag mismatch");
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_word) |=>
    (out_valid && out_word_index == $past(out_word_index) + 3'd1))
    else $error("digest index skipped");

endmodule
